[sv/sdap_pkg.sv]
// sdap_pkg: widths, register map and table builders for the distance
// attenuation and pan unit. No dependencies.
`default_nettype none

package sdap_pkg;

  localparam int POW_BITS_DEF = 8;

  localparam int POS_W  = 24;
  localparam int QUAT_W = 16;
  localparam int GAIN_W = 17;
  localparam int PAN_W  = 16;
  localparam int DIST_W = 23;
  localparam int ROLL_W = 12;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 4;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

  // register map, word index
  localparam logic [1:0] REG_NEAR    = 2'd0;
  localparam logic [1:0] REG_FAR     = 2'd1;
  localparam logic [1:0] REG_ROLLOFF = 2'd2;

  localparam logic [DIST_W-1:0] NEAR_RST    = 23'd0;
  localparam logic [DIST_W-1:0] FAR_RST     = 23'd25600;
  localparam logic [ROLL_W-1:0] ROLLOFF_RST = 12'd512;
  localparam logic [ROLL_W-1:0] ROLLOFF_MIN = 12'd26;

  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    v   = val;
    res = 64'd0;
    bt  = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // log2(1 + i/2^p), 16 fraction bits, by repeated squaring in Q30
  function automatic logic [16:0] log_entry(input int i, input int p);
    logic [63:0] x;
    logic [16:0] r;
    x = (64'd1 << 30) + (64'(i) << (30 - p));
    r = 17'd0;
    if (x >= (64'd2 << 30)) begin
      r = 17'd65536;
      x = x >> 1;
    end
    for (int k = 1; k <= 16; k++) begin
      x = (x * x) >> 30;
      if (x >= (64'd2 << 30)) begin
        x = x >> 1;
        r = r | (17'd1 << (16 - k));
      end
    end
    return r;
  endfunction

  // 2^(i/2^p) in Q16 from a product of Q30 roots
  function automatic logic [17:0] exp_entry(input int i, input int p);
    logic [63:0] v;
    logic [63:0] rt;
    logic [63:0] rv;
    v  = 64'd1 << 30;
    rt = 64'd2 << 30;
    if (i == (1 << p)) begin
      v = 64'd2 << 30;
    end else begin
      for (int k = 1; k <= p; k++) begin
        rt = isqrt64(rt << 30);
        if (((i >> (p - k)) & 1) != 0) v = (v * rt) >> 30;
      end
    end
    rv = (v + (64'd1 << 13)) >> 14;
    return rv[17:0];
  endfunction

endpackage

`default_nettype wire

[sv/sound_distance_attenuation_pan_unit.sv]
// Distance attenuation and stereo pan, top level.
// Depends on sdap_pkg and sdap_udiv.
//
// Usage:
//  - Input channel (item_valid/item_ready) takes one word per cycle while item_ready
//    is high: source and listener positions (Q15.8), listener rotation quaternion (Q1.14).
//  - Result channel (result_valid/result_ready) returns one word per input
//    word, in order: gain (Q1.16), pan (Q0.15) and updated.
//  - APB port sets near_distance (0x0), far_distance (0x4) and
//    rolloff_factor (0x8, writes below 26 stored as 26). Write only when idle.
//  - Throughput: one word per cycle while result_ready does not stall the pipe.
//    Pipe: 7 rotate/square stages, 27 square-root stages, 1 clamp stage,
//    17 divider stages, 8 log/pow stages; the square root and the gain
//    divider set most of that depth.
//  - far_distance <= near_distance: the last computed gain and pan come out
//    with updated = 0.
//  - A result_ready stall freezes the whole pipe; item_ready drops only while
//    the output register is full and not taken.
//  - Reset clears all valid bits, the held gain/pan and restores the register
//    defaults (0, 100.0, 2.0).
`default_nettype none

module sound_distance_attenuation_pan_unit #(
  parameter int POW_TABLE_BITS = sdap_pkg::POW_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic signed [sdap_pkg::POS_W-1:0]   src_x,
  input  logic signed [sdap_pkg::POS_W-1:0]   src_y,
  input  logic signed [sdap_pkg::POS_W-1:0]   src_z,
  input  logic signed [sdap_pkg::POS_W-1:0]   lis_x,
  input  logic signed [sdap_pkg::POS_W-1:0]   lis_y,
  input  logic signed [sdap_pkg::POS_W-1:0]   lis_z,
  input  logic signed [sdap_pkg::QUAT_W-1:0]  rot_w,
  input  logic signed [sdap_pkg::QUAT_W-1:0]  rot_x,
  input  logic signed [sdap_pkg::QUAT_W-1:0]  rot_y,
  input  logic signed [sdap_pkg::QUAT_W-1:0]  rot_z,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic        [sdap_pkg::GAIN_W-1:0]  gain,
  output logic signed [sdap_pkg::PAN_W-1:0]   pan,
  output logic                                updated,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic        [sdap_pkg::ADDR_W-1:0]  paddr,
  input  logic        [sdap_pkg::DATA_W-1:0]  pwdata,
  output logic        [sdap_pkg::DATA_W-1:0]  prdata,
  output logic                                pready
);

  import sdap_pkg::*;

  localparam int P      = POW_TABLE_BITS;
  localparam int SH     = 16 - P;
  localparam int TBL_N  = 1 << P;
  localparam logic [P:0] IDX_TOP = TBL_N[P:0];

  localparam int D_W    = POS_W + 1;    // position difference
  localparam int QP_W   = 2 * QUAT_W;   // quaternion product
  localparam int M_W    = QP_W + 2;     // matrix entry, Q28
  localparam int PR_W   = M_W + D_W;    // entry times difference
  localparam int S_W    = PR_W + 2;     // row sum, Q36
  localparam int ROOT_W = 27;           // rotated component / length
  localparam int MAG_W  = ROOT_W - 1;
  localparam int SUM_W  = 2 * ROOT_W;   // sum of squares
  localparam int RREM_W = ROOT_W + 2;
  localparam int BASE_F = 16;
  localparam int PAN_F  = 15;
  localparam int PD_N   = 8;            // pan delay to match the gain path
  localparam int NSTAGE = 7 + ROOT_W + 1 + (BASE_F + 1) + 8;

  localparam logic signed [M_W-1:0] ONE_Q28 = 34'sd268435456;
  localparam logic [S_W-1:0]        ROUND_HALF = 61'd134217728;
  localparam logic [32:0]           ROT_SAT = 33'd67108863;
  localparam logic [8:0]            N_LIMIT = 9'd17;

  // ---------------- tables (elaboration time) ----------------
  logic [16:0] log_tbl [TBL_N+1];
  logic [17:0] exp_tbl [TBL_N+1];

  for (genvar gi = 0; gi <= TBL_N; gi++) begin : g_tbl
    localparam logic [16:0] LV = log_entry(gi, P);
    localparam logic [17:0] EV = exp_entry(gi, P);
    assign log_tbl[gi] = LV;
    assign exp_tbl[gi] = EV;
  end

  // ---------------- configuration ----------------
  logic [DIST_W-1:0] near_dist;
  logic [DIST_W-1:0] far_dist;
  logic [ROLL_W-1:0] rolloff;
  logic              bypass;
  logic [DIST_W-1:0] interval;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_dist <= NEAR_RST;
      far_dist  <= FAR_RST;
      rolloff   <= ROLLOFF_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[ADDR_W-1:2])
        REG_NEAR:    near_dist <= pwdata[DIST_W-1:0];
        REG_FAR:     far_dist  <= pwdata[DIST_W-1:0];
        REG_ROLLOFF: rolloff   <= (pwdata[ROLL_W-1:0] < ROLLOFF_MIN) ?
                                  ROLLOFF_MIN : pwdata[ROLL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[ADDR_W-1:2])
      REG_NEAR:    prdata = {{(DATA_W-DIST_W){1'b0}}, near_dist};
      REG_FAR:     prdata = {{(DATA_W-DIST_W){1'b0}}, far_dist};
      REG_ROLLOFF: prdata = {{(DATA_W-ROLL_W){1'b0}}, rolloff};
      default:     prdata = '0;
    endcase
  end

  assign pready   = 1'b1;
  assign bypass   = far_dist <= near_dist;
  assign interval = far_dist - near_dist;

  // ---------------- flow control ----------------
  // one global advance: the pipe moves unless a finished word is stuck
  logic              adv;
  logic [NSTAGE-1:0] vld;

  assign adv          = !vld[NSTAGE-1] || result_ready;
  assign item_ready   = adv;
  assign result_valid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTAGE-2:0], item_valid};
    end
  end

  // ---------------- S1: differences, quaternion products ----------------
  logic signed [D_W-1:0]  dx1, dy1, dz1;
  logic signed [QP_W-1:0] qxx, qyy, qzz, qxy, qxz, qyz, qwx, qwy, qwz;

  always_ff @(posedge clk) begin
    if (adv) begin
      dx1 <= src_x - lis_x;
      dy1 <= src_y - lis_y;
      dz1 <= src_z - lis_z;
      qxx <= rot_x * rot_x;
      qyy <= rot_y * rot_y;
      qzz <= rot_z * rot_z;
      qxy <= rot_x * rot_y;
      qxz <= rot_x * rot_z;
      qyz <= rot_y * rot_z;
      qwx <= rot_w * rot_x;
      qwy <= rot_w * rot_y;
      qwz <= rot_w * rot_z;
    end
  end

  // ---------------- S2: transposed rotation matrix, Q28 ----------------
  logic signed [M_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic signed [D_W-1:0] dx2, dy2, dz2;

  always_ff @(posedge clk) begin
    if (adv) begin
      m00 <= ONE_Q28 - 2 * (qyy + qzz);
      m01 <= 2 * (qxy + qwz);
      m02 <= 2 * (qxz - qwy);
      m10 <= 2 * (qxy - qwz);
      m11 <= ONE_Q28 - 2 * (qxx + qzz);
      m12 <= 2 * (qyz + qwx);
      m20 <= 2 * (qxz + qwy);
      m21 <= 2 * (qyz - qwx);
      m22 <= ONE_Q28 - 2 * (qxx + qyy);
      dx2 <= dx1;
      dy2 <= dy1;
      dz2 <= dz1;
    end
  end

  // ---------------- S3: nine products ----------------
  logic signed [PR_W-1:0] p00, p01, p02, p10, p11, p12, p20, p21, p22;

  always_ff @(posedge clk) begin
    if (adv) begin
      p00 <= m00 * dx2;
      p01 <= m01 * dy2;
      p02 <= m02 * dz2;
      p10 <= m10 * dx2;
      p11 <= m11 * dy2;
      p12 <= m12 * dz2;
      p20 <= m20 * dx2;
      p21 <= m21 * dy2;
      p22 <= m22 * dz2;
    end
  end

  // ---------------- S4: row sums, Q36 ----------------
  logic signed [S_W-1:0] sx4, sy4, sz4;

  always_ff @(posedge clk) begin
    if (adv) begin
      sx4 <= p00 + p01 + p02;
      sy4 <= p10 + p11 + p12;
      sz4 <= p20 + p21 + p22;
    end
  end

  // ---------------- S5: round half away to Q8, saturate ----------------
  function automatic logic signed [ROOT_W-1:0] round_sat(input logic signed [S_W-1:0] v);
    logic [S_W-1:0]   mag;
    logic [S_W-1:0]   sum_h;
    logic [32:0]      rnd;
    logic [MAG_W-1:0] sat;
    mag   = v[S_W-1] ? S_W'(-v) : S_W'(v);
    sum_h = mag + ROUND_HALF;
    rnd   = sum_h[S_W-1:28];
    sat   = (rnd > ROT_SAT) ? ROT_SAT[MAG_W-1:0] : rnd[MAG_W-1:0];
    return v[S_W-1] ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
  endfunction

  logic signed [ROOT_W-1:0] rx_c, ry_c, rz_c;
  logic signed [ROOT_W-1:0] rx5, ry5, rz5;
  logic signed [ROOT_W-1:0] rx_neg_c;
  logic [MAG_W-1:0]         xmag5;
  logic                     xneg5;

  assign rx_c     = round_sat(sx4);
  assign ry_c     = round_sat(sy4);
  assign rz_c     = round_sat(sz4);
  assign rx_neg_c = -rx_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      rx5   <= rx_c;
      ry5   <= ry_c;
      rz5   <= rz_c;
      xneg5 <= rx_c[ROOT_W-1];
      xmag5 <= rx_c[ROOT_W-1] ? rx_neg_c[MAG_W-1:0] : rx_c[MAG_W-1:0];
    end
  end

  // ---------------- S6: squares; S7: sum of squares ----------------
  logic signed [SUM_W-1:0] sqx_c, sqy_c, sqz_c;
  logic [SUM_W-1:0]        sqx6, sqy6, sqz6;
  logic [SUM_W-1:0]        sum7;
  logic [MAG_W-1:0]        xmag6, xmag7;
  logic                    xneg6, xneg7;

  assign sqx_c = rx5 * rx5;
  assign sqy_c = ry5 * ry5;
  assign sqz_c = rz5 * rz5;

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx6  <= sqx_c;
      sqy6  <= sqy_c;
      sqz6  <= sqz_c;
      xmag6 <= xmag5;
      xneg6 <= xneg5;
      sum7  <= sqx6 + sqy6 + sqz6;
      xmag7 <= xmag6;
      xneg7 <= xneg6;
    end
  end

  // ---------------- square root, one result bit per stage ----------------
  logic [RREM_W-1:0] sq_rem  [ROOT_W];
  logic [ROOT_W-1:0] sq_root [ROOT_W];
  logic [SUM_W-1:0]  sq_val  [ROOT_W];
  logic [MAG_W-1:0]  sq_mag  [ROOT_W];
  logic              sq_neg  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [RREM_W-1:0] rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SUM_W-1:0]  val_in;
    logic [MAG_W-1:0]  mag_in;
    logic              neg_in;
    logic [RREM_W+1:0] remc;
    logic [RREM_W-1:0] trial;
    logic [RREM_W+1:0] diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign val_in  = sum7;
      assign mag_in  = xmag7;
      assign neg_in  = xneg7;
    end else begin : g_rest
      assign rem_in  = sq_rem[k-1];
      assign root_in = sq_root[k-1];
      assign val_in  = sq_val[k-1];
      assign mag_in  = sq_mag[k-1];
      assign neg_in  = sq_neg[k-1];
    end

    assign remc  = {rem_in, val_in[SUM_W-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign diff  = remc - {2'b00, trial};
    assign ge    = remc >= {2'b00, trial};

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem[k]  <= ge ? diff[RREM_W-1:0] : remc[RREM_W-1:0];
        sq_root[k] <= {root_in[ROOT_W-2:0], ge};
        sq_val[k]  <= {val_in[SUM_W-3:0], 2'b00};
        sq_mag[k]  <= mag_in;
        sq_neg[k]  <= neg_in;
      end
    end
  end

  // ---------------- D: clamp distance into the interval ----------------
  logic [ROOT_W-1:0] len_c;
  logic [ROOT_W-1:0] dist_c;
  logic [DIST_W-1:0] bnum_c;
  logic [DIST_W-1:0] bnum_d, bden_d;
  logic [ROOT_W-1:0] pnum_d, pden_d;
  logic              pneg_d, pzero_d;

  assign len_c  = sq_root[ROOT_W-1];
  assign dist_c = (len_c > ROOT_W'(near_dist)) ? len_c - ROOT_W'(near_dist) : '0;
  assign bnum_c = (dist_c >= ROOT_W'(interval)) ? '0 : interval - dist_c[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      bnum_d  <= bnum_c;
      bden_d  <= interval;
      pnum_d  <= {1'b0, sq_mag[ROOT_W-1]};
      pden_d  <= len_c;
      pneg_d  <= sq_neg[ROOT_W-1];
      pzero_d <= len_c == '0;
    end
  end

  // ---------------- dividers ----------------
  logic [BASE_F:0] base_q;
  logic [PAN_F:0]  pan_q;

  sdap_udiv #(.W(DIST_W), .F(BASE_F)) u_base_div (
    .clk (clk),
    .en  (adv),
    .num (bnum_d),
    .den (bden_d),
    .quo (base_q)
  );

  sdap_udiv #(.W(ROOT_W), .F(PAN_F)) u_pan_div (
    .clk (clk),
    .en  (adv),
    .num (pnum_d),
    .den (pden_d),
    .quo (pan_q)
  );

  // pan sign / zero-length flags ride alongside the pan divider
  logic pneg_l  [PAN_F+1];
  logic pzero_l [PAN_F+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      pneg_l[0]  <= pneg_d;
      pzero_l[0] <= pzero_d;
      for (int k = 1; k <= PAN_F; k++) begin
        pneg_l[k]  <= pneg_l[k-1];
        pzero_l[k] <= pzero_l[k-1];
      end
    end
  end

  // pan finishes one stage before the gain base; delay to the output
  logic signed [PAN_W-1:0] pan_c;
  logic [PAN_W-1:0]        pan_neg_c;
  logic signed [PAN_W-1:0] pd [PD_N];

  assign pan_neg_c = '0 - pan_q;

  always_comb begin
    if (pzero_l[PAN_F]) begin
      pan_c = '0;
    end else if (pneg_l[PAN_F]) begin
      pan_c = pan_neg_c;
    end else if (pan_q[PAN_F]) begin
      pan_c = 16'sh7fff;
    end else begin
      pan_c = pan_q;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pd[0] <= pan_c;
      for (int k = 1; k < PD_N; k++) pd[k] <= pd[k-1];
    end
  end

  // ---------------- G1: normalize base ----------------
  logic [4:0]  e_c;
  logic [16:0] m_c;
  logic [4:0]  g1_e;
  logic [15:0] g1_frac;
  logic        g1_zero;

  always_comb begin
    e_c = '0;
    for (int k = 0; k < 17; k++) begin
      if (base_q[k]) e_c = 5'(16 - k);
    end
  end

  assign m_c = base_q << e_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      g1_e    <= e_c;
      g1_frac <= m_c[15:0];
      g1_zero <= base_q == '0;
    end
  end

  // ---------------- G2: log table read ----------------
  logic [P:0]    lidx, lidx1;
  logic [16:0]   g2_l0, g2_l1;
  logic [SH-1:0] g2_rem;
  logic [4:0]    g2_e;
  logic          g2_zero;

  assign lidx  = {1'b0, g1_frac[15:SH]};
  assign lidx1 = lidx + 1'b1;

  always_ff @(posedge clk) begin
    if (adv) begin
      g2_l0   <= log_tbl[lidx];
      g2_l1   <= log_tbl[lidx1];
      g2_rem  <= g1_frac[SH-1:0];
      g2_e    <= g1_e;
      g2_zero <= g1_zero;
    end
  end

  // ---------------- G3: log interpolation ----------------
  logic [16:0]    ldiff;
  logic [16+SH:0] lprod;
  logic [16:0]    g3_l;
  logic [4:0]     g3_e;
  logic           g3_zero;

  assign ldiff = g2_l1 - g2_l0;
  assign lprod = ldiff * g2_rem;

  always_ff @(posedge clk) begin
    if (adv) begin
      g3_l    <= g2_l0 + lprod[16+SH:SH];
      g3_e    <= g2_e;
      g3_zero <= g2_zero;
    end
  end

  // ---------------- G4: -log2(base), Q16 ----------------
  logic [20:0] tb_c;
  logic [20:0] g4_t;
  logic        g4_zero;

  assign tb_c = {g3_e, 16'd0};

  always_ff @(posedge clk) begin
    if (adv) begin
      g4_t    <= (21'(g3_l) > tb_c) ? '0 : tb_c - 21'(g3_l);
      g4_zero <= g3_zero;
    end
  end

  // ---------------- G5: times rolloff ----------------
  logic [32:0] pw_c;
  logic [15:0] g5_f;
  logic [4:0]  g5_n;
  logic        g5_zero;

  assign pw_c = g4_t * rolloff;

  always_ff @(posedge clk) begin
    if (adv) begin
      g5_f    <= pw_c[23:8];
      g5_n    <= pw_c[28:24];
      g5_zero <= g4_zero || (pw_c[32:24] >= N_LIMIT);
    end
  end

  // ---------------- G6: exp table read ----------------
  logic [16:0]   ea_c;
  logic [P:0]    eidx, eidx1;
  logic [17:0]   g6_e0, g6_e1;
  logic [SH-1:0] g6_rem;
  logic [4:0]    g6_n;
  logic          g6_zero;

  assign ea_c  = 17'h10000 - {1'b0, g5_f};
  assign eidx  = ea_c[16:SH];
  assign eidx1 = (eidx == IDX_TOP) ? eidx : eidx + 1'b1;

  always_ff @(posedge clk) begin
    if (adv) begin
      g6_e0   <= exp_tbl[eidx];
      g6_e1   <= exp_tbl[eidx1];
      g6_rem  <= ea_c[SH-1:0];
      g6_n    <= g5_n;
      g6_zero <= g5_zero;
    end
  end

  // ---------------- G7: exp interpolation ----------------
  logic [17:0]    ediff;
  logic [17+SH:0] eprod;
  logic [17:0]    g7_ev;
  logic [4:0]     g7_n;
  logic           g7_zero;

  assign ediff = g6_e1 - g6_e0;
  assign eprod = ediff * g6_rem;

  always_ff @(posedge clk) begin
    if (adv) begin
      g7_ev   <= g6_e0 + eprod[17+SH:SH];
      g7_n    <= g6_n;
      g7_zero <= g6_zero;
    end
  end

  // ---------------- G8: scale by 2^-(n+1), output register ----------------
  logic [18:0]       rnd_c;
  logic [18:0]       shf_c;
  logic [GAIN_W-1:0] gain_c;
  logic [GAIN_W-1:0] held_gain;
  logic [PAN_W-1:0]  held_pan;

  assign rnd_c = {1'b0, g7_ev} + (19'd1 << g7_n);
  assign shf_c = rnd_c >> (g7_n + 5'd1);

  always_comb begin
    if (g7_zero) begin
      gain_c = '0;
    end else if (shf_c > 19'(GAIN_ONE)) begin
      gain_c = GAIN_ONE;
    end else begin
      gain_c = shf_c[GAIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (bypass) begin
        gain    <= held_gain;
        pan     <= held_pan;
        updated <= 1'b0;
      end else begin
        gain    <= gain_c;
        pan     <= pd[PD_N-1];
        updated <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_gain <= '0;
      held_pan  <= '0;
    end else if (adv && vld[NSTAGE-2] && !bypass) begin
      held_gain <= gain_c;
      held_pan  <= pd[PD_N-1];
    end
  end

endmodule

`default_nettype wire

[sv/sdap_udiv.sv]
// sdap_udiv: pipelined restoring divider, (num << F) / den for num <= den.
// One quotient bit per stage, F+1 stages. No dependencies.
`default_nettype none

module sdap_udiv #(
  parameter int W = 23,
  parameter int F = 16
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic [F:0]   quo
);

  logic [W-1:0] rem_q [F+1];
  logic [W-1:0] den_q [F+1];
  logic [F:0]   quo_q [F+1];

  for (genvar j = 0; j <= F; j++) begin : g_stage
    logic [W:0]   t;
    logic [W-1:0] dd;
    logic [F:0]   qin;
    logic [W:0]   diff;
    logic         ge;

    if (j == 0) begin : g_first
      assign t   = {1'b0, num};
      assign dd  = den;
      assign qin = '0;
    end else begin : g_rest
      assign t   = {rem_q[j-1], 1'b0};
      assign dd  = den_q[j-1];
      assign qin = quo_q[j-1];
    end

    assign ge   = t >= {1'b0, dd};
    assign diff = t - {1'b0, dd};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j] <= ge ? diff[W-1:0] : t[W-1:0];
        den_q[j] <= dd;
        quo_q[j] <= {qin[F-1:0], ge};
      end
    end
  end

  assign quo = quo_q[F];

endmodule

`default_nettype wire

[sv/sdap_checker.sv]
// sdap_checker: port-level checks for the attenuation/pan unit, bound to the top.
// Depends on sdap_pkg.
`default_nettype none

module sdap_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                item_ready,
  input logic                                result_valid,
  input logic                                result_ready,
  input logic        [sdap_pkg::GAIN_W-1:0]  gain,
  input logic signed [sdap_pkg::PAN_W-1:0]   pan,
  input logic                                updated
);

  import sdap_pkg::*;

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(gain) && $stable(pan) && $stable(updated))
    else $error("result word changed while stalled");

  // gain never exceeds unity
  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> gain <= GAIN_ONE)
    else $error("gain above full scale");

  // reset empties the pipe
  a_rst: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result word after reset");

  // an empty output register never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("input blocked with empty output");

endmodule

bind sound_distance_attenuation_pan_unit sdap_checker u_sdap_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .gain         (gain),
  .pan          (pan),
  .updated      (updated)
);

`default_nettype wire
